>>> rtl/anti_replay_window_macros.svh
// Assertion helpers for the replay window block.
`ifndef ANTI_REPLAY_WINDOW_MACROS_SVH
`define ANTI_REPLAY_WINDOW_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked property, disabled during reset.
`define ARW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must hold at every clock edge out of reset.
`define ARW_ASSERT_INV(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`else
`define ARW_ASSERT(lbl, clk, rst_n, prop, msg)
`define ARW_ASSERT_INV(lbl, clk, rst_n, expr, msg)
`endif
`endif

>>> rtl/arw_pkg.sv
`default_nettype none
package arw_pkg;

    localparam int WINDOW_BITS = 64;
    localparam int MAX_JUMP    = 1024;

    localparam int OP_W     = 2;
    localparam int INDEX_W  = 32;
    localparam int STATUS_W = 2;
    localparam int DIST_W   = 11;
    localparam int SLIDE_W  = 11;

    // offset span that passes the far test, and its derived widths
    localparam int SPAN_W    = $clog2(WINDOW_BITS + MAX_JUMP + 1);
    localparam int WIN_IDX_W = $clog2(WINDOW_BITS);
    localparam int RUN_W     = $clog2(WINDOW_BITS + 1);

    localparam logic [INDEX_W-1:0] FAR_LIMIT = INDEX_W'(WINDOW_BITS + MAX_JUMP);

    // op codes; code 3 acts as a check
    localparam logic [OP_W-1:0] OP_CHECK = 2'd0;
    localparam logic [OP_W-1:0] OP_MARK  = 2'd1;
    localparam logic [OP_W-1:0] OP_START = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OLD    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FAR    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REPLAY = 2'd3;

    typedef struct packed {
        logic [INDEX_W-1:0]     base;
        logic [WINDOW_BITS-1:0] seen;
    } arw_state_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DIST_W-1:0]   distance;
        logic [SLIDE_W-1:0]  slide_count;
        logic [INDEX_W-1:0]  base_now;
    } arw_result_t;

endpackage
`default_nettype wire

>>> rtl/arw_in_if.sv
`default_nettype none
interface arw_in_if;
    import arw_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] index;

    modport source (output valid, output op, output index, input ready);
    modport sink   (input valid, input op, input index, output ready);
endinterface
`default_nettype wire

>>> rtl/arw_out_if.sv
`default_nettype none
interface arw_out_if;
    import arw_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DIST_W-1:0]   distance;
    logic [SLIDE_W-1:0]  slide_count;
    logic [INDEX_W-1:0]  base_now;

    modport source (output valid, output status, output distance, output slide_count,
                    output base_now, input ready);
    modport sink   (input valid, input status, input distance, input slide_count,
                    input base_now, output ready);
endinterface
`default_nettype wire

>>> rtl/arw_update.sv
`default_nettype none
module arw_update (
    input  wire logic [arw_pkg::OP_W-1:0]    op,
    input  wire logic [arw_pkg::INDEX_W-1:0] index,
    input  wire arw_pkg::arw_state_t         state,
    output arw_pkg::arw_state_t              state_next,
    output arw_pkg::arw_result_t             result
);
    import arw_pkg::*;

    logic [INDEX_W-1:0]     offset;
    logic [SPAN_W-1:0]      span;
    logic                   is_old;
    logic                   is_far;
    logic                   is_replay;
    logic [STATUS_W-1:0]    status;
    logic                   beyond;
    logic [SPAN_W-1:0]      jump;
    logic [WINDOW_BITS-1:0] shifted;
    logic [WIN_IDX_W-1:0]   pos;
    logic [WINDOW_BITS-1:0] set_bits;
    logic [WINDOW_BITS-1:0] holes;
    logic [WINDOW_BITS-1:0] first_hole;
    logic [RUN_W-1:0]       run;
    logic [SPAN_W-1:0]      total;

    // classification against the current window
    assign offset    = index - state.base;
    assign span      = offset[SPAN_W-1:0];
    assign is_old    = index < state.base;
    assign is_far    = !is_old && (offset >= FAR_LIMIT);
    assign is_replay = !is_old && (offset < INDEX_W'(WINDOW_BITS))
                       && state.seen[offset[WIN_IDX_W-1:0]];

    always_comb
    begin
        if (is_old)
            status = ST_OLD;
        else if (is_far)
            status = ST_FAR;
        else if (is_replay)
            status = ST_REPLAY;
        else
            status = ST_OK;
    end

    // slide so the offset lands on the top bit; a shift past the width clears all
    assign beyond  = span >= SPAN_W'(WINDOW_BITS);
    assign jump    = span - SPAN_W'(WINDOW_BITS - 1);
    assign shifted = beyond ? (state.seen >> jump) : state.seen;
    assign pos     = beyond ? WIN_IDX_W'(WINDOW_BITS - 1) : span[WIN_IDX_W-1:0];
    assign set_bits = shifted | (WINDOW_BITS'(1) << pos);

    // length of the run of set bits at the bottom
    assign holes      = ~set_bits;
    assign first_hole = holes & (~holes + WINDOW_BITS'(1));

    always_comb
    begin
        run = '0;
        for (int i = 0; i < WINDOW_BITS; i++)
        begin
            if (first_hole[i])
                run = run | RUN_W'(i);
        end
        if (holes == '0)
            run = RUN_W'(WINDOW_BITS);
    end

    assign total = (beyond ? jump : SPAN_W'(0)) + SPAN_W'(run);

    always_comb
    begin
        state_next         = state;
        result.status      = status;
        result.distance    = (status == ST_OK) ? DIST_W'(span) : DIST_W'(0);
        result.slide_count = '0;
        case (op)
            OP_START:
            begin
                state_next.base    = index;
                state_next.seen    = '0;
                result.status      = ST_OK;
                result.distance    = '0;
            end
            OP_MARK:
            begin
                if (status == ST_OK)
                begin
                    state_next.base    = state.base + INDEX_W'(total);
                    state_next.seen    = set_bits >> run;
                    result.slide_count = SLIDE_W'(total);
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
        result.base_now = state_next.base;
    end
endmodule
`default_nettype wire

>>> rtl/anti_replay_window.sv
// Replay window: a request is held in the input stage, classified against the
// window, and its result is registered in the result stage.
// Throughput 1 item per cycle while rsp.ready does not stall the result slot; the
// window state feeds back from state_reg, so back-to-back items each see the state left by the one before.
// rst_n (async, active low) clears the base to 0, the seen bitmap to all zeros
// and both pipeline stages to empty; no clearing pass is needed.
`default_nettype none
`include "anti_replay_window_macros.svh"
module anti_replay_window (
    input  wire logic clk,
    input  wire logic rst_n,
    arw_in_if.sink    req,
    arw_out_if.source rsp
);
    import arw_pkg::*;

    // input stage
    logic               in_valid_reg;
    logic [OP_W-1:0]    op_reg;
    logic [INDEX_W-1:0] index_reg;

    // window state
    arw_state_t state_reg;
    arw_state_t state_next;

    // result stage
    logic        out_valid_reg;
    arw_result_t result_reg;
    arw_result_t result_next;

    logic advance;
    logic take_in;

    // The input stage moves on when the result slot is empty or being
    // drained; while a finished result waits, the request side still takes
    // one more item into the empty input stage.
    assign advance = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign take_in = req.valid && req.ready;
    assign req.ready = !in_valid_reg || advance;

    arw_update u_update (
        .op         (op_reg),
        .index      (index_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (take_in)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;

            // state commits together with the result transfer into the slot
            if (advance)
                state_reg <= state_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            op_reg    <= req.op;
            index_reg <= req.index;
        end
        if (advance)
            result_reg <= result_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = result_reg.status;
    assign rsp.distance    = result_reg.distance;
    assign rsp.slide_count = result_reg.slide_count;
    assign rsp.base_now    = result_reg.base_now;

    // window always slides past its bottom run, so bit 0 is never left set
    `ARW_ASSERT_INV(a_bottom_clear, clk, rst_n, !state_reg.seen[0], "bottom bit left set")

    // rejected items leave the window alone
    `ARW_ASSERT(a_reject_keeps_state, clk, rst_n, advance && (result_next.status != ST_OK) |=> $stable(state_reg), "state changed on reject")

    // only an ok mark can slide the window
    `ARW_ASSERT_INV(a_slide_only_mark, clk, rst_n, !advance || (op_reg == OP_MARK) || (result_next.slide_count == '0), "slide without mark")

    // a held input item is neither lost nor overwritten
    `ARW_ASSERT(a_in_hold, clk, rst_n, in_valid_reg && !advance |=> in_valid_reg && $stable(index_reg) && $stable(op_reg), "input stage lost item")
endmodule
`default_nettype wire
